// ===== hdl/astg_pkg.sv =====
// shared types, codes and legality table of the axis state transition guard
package astg_pkg;

	// axis states
	typedef enum logic [2:0] {
		ST_DISABLED     = 3'd0,
		ST_STANDSTILL   = 3'd1,
		ST_HOMING       = 3'd2,
		ST_DISCRETE     = 3'd3,
		ST_CONTINUOUS   = 3'd4,
		ST_SYNCHRONIZED = 3'd5,
		ST_STOPPING     = 3'd6,
		ST_ERRORSTOP    = 3'd7
	} axis_state_t;

	// request kinds
	typedef enum logic [1:0] {
		REQ_TEST  = 2'd0,
		REQ_SET   = 2'd1,
		REQ_ERROR = 2'd2,
		REQ_POWER = 2'd3
	} req_type_t;

	localparam int unsigned CODE_W = 4;
	localparam logic [CODE_W-1:0] CODE_GOOD = 4'd0;

	// bit t of entry c is set when a move from state c to state t is allowed
	localparam logic [7:0] LEGAL_MOVES [8] = '{
		8'h00, // disabled
		8'h7C, // standstill
		8'h42, // homing
		8'h7A, // discrete
		8'h7A, // continuous
		8'h7A, // synchronized
		8'h02, // stopping
		8'h00  // error stop
	};

	// outcome of one request
	typedef struct packed {
		logic [CODE_W-1:0] code;
		axis_state_t       next_state;
	} eval_res_t;

endpackage

// ===== hdl/astg_if.sv =====
// request and response channel interfaces of the axis state transition guard

interface astg_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic [2:0] target_state;
	logic       power_on;

	modport source (output valid, req_type, target_state, power_on, input ready);
	modport sink (input valid, req_type, target_state, power_on, output ready);
endinterface

interface astg_rsp_if;
	logic       valid;
	logic       ready;
	logic [3:0] result_code;
	logic [2:0] current_state;

	modport source (output valid, result_code, current_state, input ready);
	modport sink (input valid, result_code, current_state, output ready);
endinterface

// ===== hdl/astg_eval.sv =====
// combinational evaluation of one request against the current axis state
module astg_eval (
	input  astg_pkg::axis_state_t cur_state,
	input  astg_pkg::req_type_t   req_type,
	input  astg_pkg::axis_state_t target_state,
	input  logic                  power_on,
	output astg_pkg::eval_res_t   res
);
	import astg_pkg::*;

	logic              move_ok;
	logic [CODE_W-1:0] refuse_code;

	// same state always passes, otherwise the table decides
	assign move_ok = (target_state == cur_state) ||
		LEGAL_MOVES[cur_state][target_state];
	assign refuse_code = {1'b0, cur_state} + 4'd1;

	// request decode
	always_comb begin
		res.code       = CODE_GOOD;
		res.next_state = cur_state;
		unique case (req_type)
			REQ_TEST: begin
				res.code = move_ok ? CODE_GOOD : refuse_code;
			end
			REQ_SET: begin
				res.code = move_ok ? CODE_GOOD : refuse_code;
				if (move_ok) begin
					res.next_state = target_state;
				end
			end
			REQ_ERROR: begin
				res.next_state = ST_ERRORSTOP;
			end
			REQ_POWER: begin
				res.next_state = power_on ? ST_STANDSTILL : ST_DISABLED;
			end
			default: begin
				res.next_state = cur_state;
			end
		endcase
	end

endmodule

// ===== hdl/axis_state_transition_guard_top.sv =====
// top level of the axis state transition guard: input stage, state and result stage
// a request passes the input register, then the result register, before its response is valid
// throughput: one item per cycle unless rsp.ready stalls; the state update is a single table lookup and register write
// the response register lets a new item enter while an earlier result waits to be taken
// reset: arst_n clears both stage valids and returns the axis state to disabled
module axis_state_transition_guard_top (
	input logic      clk,
	input logic      arst_n,
	astg_req_if.sink   req,
	astg_rsp_if.source rsp
);
	import astg_pkg::*;

	logic              valid_s1;
	req_type_t         req_type_s1;
	axis_state_t       target_state_s1;
	logic              power_on_s1;

	logic              valid_s2;
	logic [CODE_W-1:0] result_code_s2;
	axis_state_t       current_state_s2;

	axis_state_t       state_q;
	eval_res_t         res;
	logic              adv_s2;
	logic              acc_in;

	// handshake and stage advance
	assign adv_s2    = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || adv_s2;
	assign acc_in    = req.valid && req.ready;

	// input stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (acc_in) begin
			valid_s1 <= 1'b1;
		end else if (adv_s2) begin
			valid_s1 <= 1'b0;
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (acc_in) begin
			req_type_s1     <= req_type_t'(req.req_type);
			target_state_s1 <= axis_state_t'(req.target_state);
			power_on_s1     <= req.power_on;
		end
	end

	// request evaluation
	astg_eval u_eval (
		.cur_state    (state_q),
		.req_type     (req_type_s1),
		.target_state (target_state_s1),
		.power_on     (power_on_s1),
		.res          (res)
	);

	// axis state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_DISABLED;
		end else if (adv_s2) begin
			state_q <= res.next_state;
		end
	end

	// result stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= 1'b1;
		end else if (rsp.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	// result stage payload
	always_ff @(posedge clk) begin
		if (adv_s2) begin
			result_code_s2   <= res.code;
			current_state_s2 <= res.next_state;
		end
	end

	assign rsp.valid         = valid_s2;
	assign rsp.result_code   = result_code_s2;
	assign rsp.current_state = current_state_s2;

	// state moves only when an item leaves the input stage
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s2 |=> $stable(state_q))
		else $error("axis state changed without an item");

	// reported state matches the kept state right after an item
	a_report_state: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s2 |=> (current_state_s2 == state_q))
		else $error("reported state differs from axis state");

	// a refused item leaves the state it names
	a_refuse_same: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && (result_code_s2 != CODE_GOOD)) |->
		(({1'b0, current_state_s2} + 4'd1) == result_code_s2))
		else $error("refusal code does not name the current state");

	// error event forces error stop
	a_error_stop: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s2 && (req_type_s1 == REQ_ERROR)) |=> (state_q == ST_ERRORSTOP))
		else $error("error event did not reach error stop");

endmodule

// ===== test/astg_checker.sv =====
// checker for the axis state transition guard: watches both channels, predicts and compares
module astg_checker (
	input  logic  clk,
	input  logic  arst_n,
	astg_req_if   req,
	astg_rsp_if   rsp,
	output int    fail_count,
	output int    pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import astg_pkg::*;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		axis_state_t       state;
	} guard_result_t;

	axis_state_t   tracked_state;
	guard_result_t expected_results [$];

	// moves to a different state that the axis may take
	function automatic logic move_permitted(axis_state_t from, axis_state_t to);
		logic ok;
		case (from)
			ST_STANDSTILL: begin
				ok = (to != ST_DISABLED) && (to != ST_ERRORSTOP);
			end
			ST_HOMING: begin
				ok = (to == ST_STANDSTILL) || (to == ST_STOPPING);
			end
			ST_DISCRETE, ST_CONTINUOUS, ST_SYNCHRONIZED: begin
				ok = (to != ST_DISABLED) && (to != ST_HOMING) && (to != ST_ERRORSTOP);
			end
			ST_STOPPING: begin
				ok = (to == ST_STANDSTILL);
			end
			default: begin
				ok = 1'b0;
			end
		endcase
		return ok;
	endfunction

	// applies one request to the tracked state and returns the response it should give
	function automatic guard_result_t apply_request(req_type_t kind, axis_state_t target,
			logic pwr);
		guard_result_t res;
		logic [CODE_W-1:0] verdict;
		verdict = CODE_GOOD;
		if (kind == REQ_TEST || kind == REQ_SET) begin
			if (target != tracked_state && !move_permitted(tracked_state, target))
				verdict = CODE_W'(tracked_state) + CODE_W'(1);
			if (kind == REQ_SET && verdict == CODE_GOOD)
				tracked_state = target;
		end else if (kind == REQ_ERROR) begin
			tracked_state = ST_ERRORSTOP;
		end else begin
			tracked_state = pwr ? ST_STANDSTILL : ST_DISABLED;
		end
		res.code  = verdict;
		res.state = tracked_state;
		return res;
	endfunction

	task automatic report_mismatch(input string what);
		$display("%0t ns: mismatch: %s", $time, what);
		fail_count++;
	endtask

	initial begin
		fail_count    = 0;
		pending       = 0;
		tracked_state = ST_DISABLED;
	end

	// compare each response item with the oldest prediction, then predict for new requests
	always @(posedge clk) begin
		guard_result_t exp_res;
		if (arst_n) begin
			if (rsp.valid && rsp.ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("response item code %0d state %0d with none expected",
						rsp.result_code, rsp.current_state));
				end else begin
					exp_res = expected_results.pop_front();
					if (rsp.result_code !== exp_res.code)
						report_mismatch($sformatf("result_code %0d, expected %0d",
							rsp.result_code, exp_res.code));
					if (rsp.current_state !== exp_res.state)
						report_mismatch($sformatf("current_state %0d, expected %0d",
							rsp.current_state, exp_res.state));
				end
			end
			if (req.valid && req.ready)
				expected_results.push_back(apply_request(req_type_t'(req.req_type),
					axis_state_t'(req.target_state), req.power_on));
			pending = expected_results.size();
		end
	end

	final begin
		if (expected_results.size() != 0)
			$display("%0d response items still expected", expected_results.size());
	end

endmodule

// ===== test/axis_state_transition_guard_top_tb.sv =====
// top of the axis state transition guard testbench: clock, reset, stimulus and verdict
module axis_state_transition_guard_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import astg_pkg::*;

	localparam int RANDOM_ITEMS = 1700;
	localparam int DRAIN_CYCLES = 10;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	logic burst_mode;

	astg_req_if req_ch ();
	astg_rsp_if rsp_ch ();

	axis_state_transition_guard_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	astg_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#10ms;
		$display("Test completed with failures");
		$finish;
	end

	// gap length: mostly none, some short, a few long; none at all in burst stretches
	function automatic int idle_cycles();
		int r;
		if (burst_mode)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// present one request item and hold it until accepted, then idle for a random gap that may be none
	task automatic send_request(input req_type_t kind, input axis_state_t target,
			input logic pwr);
		int gap;
		req_ch.valid        <= 1'b1;
		req_ch.req_type     <= kind;
		req_ch.target_state <= target;
		req_ch.power_on     <= pwr;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		gap = idle_cycles();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// random request mix: mostly tests and sets, enough power events to leave dead states
	function automatic req_type_t random_kind();
		int r;
		r = $urandom_range(0, 99);
		if (r < 30)
			return REQ_TEST;
		if (r < 75)
			return REQ_SET;
		if (r < 83)
			return REQ_ERROR;
		return REQ_POWER;
	endfunction

	// response side backpressure
	initial begin
		int run;
		int stall;
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			run = $urandom_range(1, 8);
			rsp_ch.ready <= 1'b1;
			repeat (run) @(posedge clk);
			stall = idle_cycles();
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	// reset, directed items, random items, drain and verdict
	initial begin
		req_type_t kind;
		logic      pwr;
		arst_n              <= 1'b0;
		burst_mode          <= 1'b0;
		req_ch.valid        <= 1'b0;
		req_ch.req_type     <= REQ_TEST;
		req_ch.target_state <= ST_DISABLED;
		req_ch.power_on     <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// disabled accepts only itself; power on leads out
		send_request(REQ_TEST, ST_DISABLED, 1'b1);
		send_request(REQ_TEST, ST_STANDSTILL, 1'b0);
		send_request(REQ_SET, ST_ERRORSTOP, 1'b1);
		send_request(REQ_POWER, ST_ERRORSTOP, 1'b1);
		// standstill to homing, homing refuses motion, back through standstill
		send_request(REQ_TEST, ST_ERRORSTOP, 1'b0);
		send_request(REQ_SET, ST_HOMING, 1'b0);
		send_request(REQ_SET, ST_DISCRETE, 1'b1);
		send_request(REQ_SET, ST_STANDSTILL, 1'b0);
		// walk through the motion states
		send_request(REQ_SET, ST_DISCRETE, 1'b0);
		send_request(REQ_SET, ST_CONTINUOUS, 1'b0);
		send_request(REQ_SET, ST_SYNCHRONIZED, 1'b1);
		send_request(REQ_SET, ST_SYNCHRONIZED, 1'b0);
		send_request(REQ_SET, ST_HOMING, 1'b0);
		send_request(REQ_SET, ST_STOPPING, 1'b0);
		// stopping only goes to standstill
		send_request(REQ_TEST, ST_HOMING, 1'b1);
		send_request(REQ_SET, ST_DISABLED, 1'b0);
		send_request(REQ_SET, ST_STANDSTILL, 1'b0);
		// error event ignores target and power level; error stop refuses sets and only a power event leaves it
		send_request(REQ_ERROR, ST_SYNCHRONIZED, 1'b1);
		send_request(REQ_TEST, ST_ERRORSTOP, 1'b0);
		send_request(REQ_SET, ST_STANDSTILL, 1'b1);
		send_request(REQ_POWER, ST_HOMING, 1'b0);
		send_request(REQ_ERROR, ST_DISABLED, 1'b0);
		send_request(REQ_POWER, ST_DISABLED, 1'b1);
		send_request(REQ_POWER, ST_STANDSTILL, 1'b1);

		// random items in stretches, some without any idling
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 200 == 0)
				burst_mode <= ($urandom_range(0, 3) == 0);
			kind = random_kind();
			pwr  = (kind == REQ_POWER) ? ($urandom_range(0, 9) != 0) :
				($urandom_range(0, 1) != 0);
			send_request(kind, axis_state_t'($urandom_range(0, 7)), pwr);
		end
		req_ch.valid <= 1'b0;

		// drain outstanding responses
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
